/* design/kscd_pkg.sv */
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared types, scancode constants and character tables for the set-1
// scancode decoder.
// ----------------------------------------------------------------------------
package kscd_pkg;

    // Scancode values
    localparam logic [7:0] SC_PREFIX       = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

    // Event kinds
    localparam logic EV_KEY_DOWN = 1'b0;
    localparam logic EV_KEY_UP   = 1'b1;

    // Keyboard state flags
    typedef struct packed {
        logic prefix;
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } kscd_flags_t;

    // One decoded event, before the device stamp
    typedef struct packed {
        logic       emit;
        logic       kind;
        logic [6:0] key;
        logic [3:0] mods;
        logic [6:0] ch;
    } kscd_event_t;

    // Unshifted character table
    function automatic logic [6:0] plain_char(input logic [6:0] key);
        logic [6:0] c;
        unique case (key)
            7'd1:  c = 7'd27;
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd14: c = 7'd8;
            7'd15: c = 7'd9;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'd10;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'd39;
            7'd41: c = 7'h60;
            7'd43: c = 7'd92;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

    // Shifted character table; keys that do not change fall back to plain
    function automatic logic [6:0] shifted_char(input logic [6:0] key);
        logic [6:0] c;
        unique case (key)
            7'd2:  c = 7'h21;
            7'd3:  c = 7'h40;
            7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;
            7'd6:  c = 7'h25;
            7'd7:  c = 7'h5E;
            7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;
            7'd10: c = 7'h28;
            7'd11: c = 7'h29;
            7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;
            7'd39: c = 7'h3A;
            7'd40: c = 7'd34;
            7'd41: c = 7'h7E;
            7'd43: c = 7'h7C;
            7'd51: c = 7'h3C;
            7'd52: c = 7'h3E;
            7'd53: c = 7'h3F;
            default: c = plain_char(key);
        endcase
        return c;
    endfunction

endpackage

/* design/keyboard_scancode_decoder_top.sv */
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_top
// Set-1 scancode to key event decoder with modifier tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, scancode) takes one scancode byte per
//   beat. Output channel (out_valid/out_ready) gives one key event per byte
//   that is not dropped: zero bytes, the 0xE0 prefix and the byte after it
//   give nothing, and no event leaves while device_id is zero.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes device_id; it is
//   always ready. It is to be written only while the block is idle; the
//   block itself does not enforce this. A byte sits in the input register,
//   then is decoded into the result register, which loads when it is free
//   or being taken. Throughput: one byte per cycle while the receiver does
//   not stall, set by the single decode stage between the two registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more byte, after which in_ready drops until the result
//   is taken.
//   Reset clears all flags, device_id and both valid bits.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    // config
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // scancode input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scancode,
    // event output
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_kind,
    output logic [6:0] key_number,
    output logic [3:0] modifier_bits,
    output logic [6:0] ascii_char,
    output logic [7:0] source_device
);
    import kscd_pkg::*;

    logic        dev_id_wr;
    logic [7:0]  dev_id_reg;
    logic        in_vld_reg;
    logic [7:0]  in_code_reg;
    kscd_flags_t flags_reg;
    kscd_flags_t flags_next;
    kscd_event_t dec_event;
    logic        advance;
    logic        out_vld_reg;
    logic        out_vld_next;
    kscd_event_t out_event_reg;
    logic [7:0]  out_dev_reg;

    // Config register
    assign cfg_ready = 1'b1;
    assign dev_id_wr = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_id_reg <= '0;
        else if (dev_id_wr)
            dev_id_reg <= cfg_data;
    end

    // Stage control
    assign advance  = ~out_vld_reg | out_ready;
    assign in_ready = ~in_vld_reg | advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_code_reg <= scancode;
    end

    // Decode
    kscd_decode u_decode (
        .scancode   (in_code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .event_out  (dec_event)
    );

    // Flags update as the byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (in_vld_reg && advance)
            flags_reg <= flags_next;
    end

    // Result register
    assign out_vld_next = in_vld_reg & dec_event.emit & (dev_id_reg != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && out_vld_next)
        begin
            out_event_reg <= dec_event;
            out_dev_reg   <= dev_id_reg;
        end
    end

    assign out_valid     = out_vld_reg;
    assign event_kind    = out_event_reg.kind;
    assign key_number    = out_event_reg.key;
    assign modifier_bits = out_event_reg.mods;
    assign ascii_char    = out_event_reg.ch;
    assign source_device = out_dev_reg;

    // Checks
    a_dev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (source_device != 8'd0))
        else $error("event with zero device id");

    a_up_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == EV_KEY_UP) |-> (ascii_char == 7'd0))
        else $error("key up carries a character");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_no_event_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_vld_reg && !out_valid) |=> !out_valid)
        else $error("event appeared with no byte in flight");

endmodule

/* design/kscd_decode.sv */
// ----------------------------------------------------------------------------
// kscd_decode
// Combinational decode of one scancode byte against the current flags:
// next flags and the event it produces.
// ----------------------------------------------------------------------------
module kscd_decode (
    input  logic [7:0]           scancode,
    input  kscd_pkg::kscd_flags_t flags,
    output kscd_pkg::kscd_flags_t flags_next,
    output kscd_pkg::kscd_event_t event_out
);
    import kscd_pkg::*;

    logic [6:0] key;
    logic       is_break;
    logic [6:0] base;
    logic       is_letter;

    assign key      = scancode[6:0];
    assign is_break = scancode[7];
    assign base     = plain_char(key);
    assign is_letter = (base >= 7'h61) && (base <= 7'h7A);

    // Flag update and event decode
    always_comb
    begin
        flags_next = flags;
        event_out  = '0;
        priority if (scancode == 8'h00)
        begin
            // ignored byte
        end
        else if (scancode == SC_PREFIX)
        begin
            flags_next.prefix = 1'b1;
        end
        else if (flags.prefix)
        begin
            // byte after the prefix is dropped
            flags_next.prefix = 1'b0;
        end
        else
        begin
            priority if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE)
                flags_next.shift = 1'b1;
            else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK)
                flags_next.shift = 1'b0;
            else if (scancode == SC_CTRL_MAKE)
                flags_next.ctrl = 1'b1;
            else if (scancode == SC_CTRL_BREAK)
                flags_next.ctrl = 1'b0;
            else if (scancode == SC_ALT_MAKE)
                flags_next.alt = 1'b1;
            else if (scancode == SC_ALT_BREAK)
                flags_next.alt = 1'b0;
            else if (scancode == SC_CAPS_MAKE)
                flags_next.caps = ~flags.caps;
            else
            begin
                // not a modifier
            end

            event_out.emit = 1'b1;
            event_out.kind = is_break ? EV_KEY_UP : EV_KEY_DOWN;
            event_out.key  = key;
            event_out.mods = {flags_next.caps, flags_next.alt,
                              flags_next.ctrl, flags_next.shift};
            // character uses flags after this byte's update
            priority if (is_break)
                event_out.ch = 7'd0;
            else if (is_letter)
                event_out.ch = (flags_next.shift ^ flags_next.caps)
                             ? (base & 7'h5F) : base;
            else if (flags_next.shift)
                event_out.ch = shifted_char(key);
            else
                event_out.ch = base;
        end
    end

endmodule
